### hdl/rrtm_pkg.sv
// Package for the reading ring tolerance match block: types, codes and reset values.
package rrtm_pkg;

  // Default ring depth.
  localparam int DEPTH_DEF = 16;

  // Register reset values.
  localparam logic [15:0] TIME_WINDOW_RST = 16'd100;
  localparam logic [15:0] HEIGHT_TOL_RST  = 16'd300;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_TOL  = 2'd1;

  // Command codes.
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Input beat.
  typedef struct packed {
    logic        command;
    logic [15:0] height;
    logic [31:0] stamp;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic        found;
    logic [15:0] matched_height;
    logic [31:0] matched_stamp;
  } out_t;

  // One stored reading.
  typedef struct packed {
    logic [15:0] height;
    logic [31:0] stamp;
    logic [7:0]  x_pos;
    logic [7:0]  y_pos;
  } slot_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

### hdl/reading_ring_tolerance_match_top.sv
// Top level of the reading ring tolerance match block: ring memory and scan sequencer.
//
// Usage:
//   The input channel (in_valid, in_stall, in_data) carries one command per beat.
//   A record beat writes its reading into the ring slot at the write pointer,
//   overwriting the oldest reading once all DEPTH slots are filled, and gives
//   no result.
//   A query beat scans the valid slots from slot 0 upward through the one-port
//   ring memory, one slot read per cycle, and stops at the first slot with equal
//   x and y, a stamp within time_window and a height within height_tolerance.
//   A query returns one result beat (found, matched_height, matched_stamp) on the
//   output channel; the input stays stalled from the query's acceptance until its
//   result is loaded into the output register. The output register holds a
//   finished result while out_stall is high; the block still takes new beats then,
//   and a later query waits for the register to free. Configuration (cfg_we,
//   cfg_idx, cfg_wdata) is to be written by the user only while the block is idle;
//   the block itself does not enforce this. Synchronous reset (rst_n low) empties
//   the ring, zeroes the write pointer and restores the register defaults; ring
//   memory contents are not cleared.
module reading_ring_tolerance_match_top #(
  parameter int DEPTH = rrtm_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rrtm_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rrtm_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [rrtm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [rrtm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rrtm_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);

  // Control registers.
  state_t         state_r, state_nxt;
  logic [AW-1:0]  wp_r, wp_nxt;
  logic [CW-1:0]  fill_r, fill_nxt;
  logic [CW-1:0]  issue_r, issue_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic           cmp_last_r, cmp_last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [15:0]    tw_r, tw_nxt;
  logic [15:0]    ht_r, ht_nxt;

  // Payload registers.
  in_t            qry_r, qry_nxt;
  out_t           res_r, res_nxt;
  out_t           out_data_r, out_data_nxt;

  // Ring memory.
  slot_t          ring_mem [DEPTH];
  slot_t          rd_data_r;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           wr_en;

  logic           in_acc;
  logic           out_load;
  logic [31:0]    stamp_diff;
  logic [15:0]    height_diff;
  logic           hit;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign wr_en     = in_acc && (in_data.command == CMD_RECORD);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_r] <= '{height: in_data.height, stamp: in_data.stamp,
                          x_pos: in_data.x_pos, y_pos: in_data.y_pos};
    end
    if (rd_en) begin
      rd_data_r <= ring_mem[rd_addr];
    end
  end

  // Match test on the slot read in the previous cycle.
  always_comb begin
    stamp_diff  = (rd_data_r.stamp >= qry_r.stamp) ? (rd_data_r.stamp - qry_r.stamp)
                                                    : (qry_r.stamp - rd_data_r.stamp);
    height_diff = (rd_data_r.height >= qry_r.height) ? (rd_data_r.height - qry_r.height)
                                                      : (qry_r.height - rd_data_r.height);
    hit = (rd_data_r.x_pos == qry_r.x_pos) && (rd_data_r.y_pos == qry_r.y_pos) &&
          (stamp_diff <= {16'd0, tw_r}) && (height_diff <= ht_r);
  end

  // Configuration writes.
  always_comb begin
    tw_nxt = tw_r;
    ht_nxt = ht_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_TIME_WINDOW: tw_nxt = cfg_wdata;
        CFG_HEIGHT_TOL:  ht_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: next state and outputs.
  always_comb begin
    state_nxt    = state_r;
    wp_nxt       = wp_r;
    fill_nxt     = fill_r;
    issue_nxt    = issue_r;
    cmp_vld_nxt  = 1'b0;
    cmp_last_nxt = cmp_last_r;
    qry_nxt      = qry_r;
    res_nxt      = res_r;
    rd_en        = 1'b0;
    rd_addr      = issue_r[AW-1:0];
    out_load     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.command == CMD_RECORD) begin
            wp_nxt = (wp_r == LAST_IDX) ? '0 : wp_r + 1'b1;
            if (fill_r != FULL) begin
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            qry_nxt   = in_data;
            issue_nxt = '0;
            res_nxt   = '0;
            state_nxt = (fill_r == '0) ? ST_DONE : ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // Issue the next slot read while slots remain.
        if (issue_r < fill_r) begin
          rd_en        = 1'b1;
          issue_nxt    = issue_r + 1'b1;
          cmp_vld_nxt  = 1'b1;
          cmp_last_nxt = ((issue_r + 1'b1) == fill_r);
        end
        // Judge the slot read in the previous cycle.
        if (cmp_vld_r) begin
          if (hit) begin
            res_nxt     = '{found: 1'b1, matched_height: rd_data_r.height,
                            matched_stamp: rd_data_r.stamp};
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (cmp_last_r) begin
            cmp_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_load || (out_valid_r && out_stall);
    out_data_nxt  = out_load ? res_r : out_data_r;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      issue_r     <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_last_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tw_r        <= TIME_WINDOW_RST;
      ht_r        <= HEIGHT_TOL_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      cmp_last_r  <= cmp_last_nxt;
      out_valid_r <= out_valid_nxt;
      tw_r        <= tw_nxt;
      ht_r        <= ht_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    qry_r      <= qry_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hdl/rrtm_checker.sv
// Port-level checker for the reading ring tolerance match block, with its bind.
module rrtm_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input rrtm_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_stall,
  input rrtm_pkg::out_t out_data
);
  import rrtm_pkg::*;

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // A result without a match carries zero fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.matched_height == '0 &&
                                    out_data.matched_stamp == '0)
    else $error("no-match result has nonzero fields");

  // Reset empties the output register.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A record beat never produces a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_RECORD && !out_valid |=> !out_valid)
    else $error("record beat produced a result");

  // A query keeps the input stalled while it scans.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.command == CMD_QUERY |=> in_stall)
    else $error("input taken during a query");

endmodule

bind reading_ring_tolerance_match_top rrtm_checker u_rrtm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/testbench.sv
// Self-checking testbench for the reading ring tolerance match block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rrtm_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEF;
  // Covers the longest scan, with some margin on top.
  localparam int QUIET_CYCLES = RING_DEPTH + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int MAX_PRINTED = 50;
  // Register indexes that the block has no register for.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED_B = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow copy of the ring and the registers.
  slot_t ring [RING_DEPTH];
  int unsigned ring_wr = 0;
  int unsigned ring_fill = 0;
  logic [15:0] win_cfg = TIME_WINDOW_RST;
  logic [15:0] tol_cfg = HEIGHT_TOL_RST;
  out_t pending_answers[$];

  int err_count = 0;
  int idle_cycles = 0;
  bit hold_req = 1'b0;
  logic [31:0] stamp_now = 32'd0;
  logic [15:0] height_base = 16'd0;

  reading_ring_tolerance_match_top #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_PRINTED) begin
      $display("%0t mismatch: %s", $realtime, msg);
    end
    err_count++;
  endtask

  // Search the shadow ring the way the block does: lowest valid slot first.
  function automatic out_t lookup_alert(input in_t a);
    out_t r;
    logic [31:0] sdiff;
    logic [15:0] hdiff;
    r = '0;
    for (int i = 0; i < ring_fill; i++) begin
      sdiff = (ring[i].stamp >= a.stamp) ? ring[i].stamp - a.stamp : a.stamp - ring[i].stamp;
      hdiff = (ring[i].height >= a.height) ? ring[i].height - a.height
                                           : a.height - ring[i].height;
      if (!r.found && ring[i].x_pos == a.x_pos && ring[i].y_pos == a.y_pos &&
          sdiff <= {16'd0, win_cfg} && hdiff <= tol_cfg) begin
        r.found = 1'b1;
        r.matched_height = ring[i].height;
        r.matched_stamp = ring[i].stamp;
      end
    end
    return r;
  endfunction

  // Update the shadow state for one accepted beat.
  task automatic apply_beat(input in_t b);
    if (b.command == CMD_RECORD) begin
      ring[ring_wr] = '{b.height, b.stamp, b.x_pos, b.y_pos};
      ring_wr = (ring_wr + 1) % RING_DEPTH;
      if (ring_fill < RING_DEPTH) ring_fill++;
    end else begin
      pending_answers.push_back(lookup_alert(b));
    end
  endtask

  // Offer one beat from a falling edge; return at the falling edge after it is taken.
  task automatic send_beat(input in_t b);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    apply_beat(b);
    @(negedge clk);
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  // Stop sending until every answer is back and the block has gone quiet.
  task automatic drain_answers();
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  // Write both registers and one unused index, only while the block is idle.
  task automatic set_config(input logic [15:0] window, input logic [15:0] tol);
    drain_answers();
    cfg_we <= 1'b1;
    cfg_idx <= CFG_TIME_WINDOW;
    cfg_wdata <= window;
    @(negedge clk);
    cfg_idx <= CFG_HEIGHT_TOL;
    cfg_wdata <= tol;
    @(negedge clk);
    cfg_idx <= ($urandom_range(1, 0) != 0) ? CFG_IDX_UNUSED_A : CFG_IDX_UNUSED_B;
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    win_cfg = window;
    tol_cfg = tol;
    @(negedge clk);
  endtask

  function automatic in_t beat(input logic cmd, input logic [15:0] h, input logic [31:0] s,
                               input logic [7:0] x, input logic [7:0] y);
    in_t b;
    b.command = cmd;
    b.height = h;
    b.stamp = s;
    b.x_pos = x;
    b.y_pos = y;
    return b;
  endfunction

  // Offset around a limit: inside, on the edge, just past it or well past it.
  function automatic int near_offset(input int lim);
    int off;
    case ($urandom_range(4, 0))
      0: off = int'($urandom_range(2 * lim, 0)) - lim;
      1: off = lim;
      2: off = -lim;
      3: off = ($urandom_range(1, 0) != 0) ? lim + 1 : -lim - 1;
      default: off = lim + 1 + int'($urandom_range(1000, 0));
    endcase
    return off;
  endfunction

  function automatic in_t gen_record();
    in_t b;
    b.command = CMD_RECORD;
    if ($urandom_range(9, 0) < 2) begin
      b.height = 16'($urandom);
      b.stamp = $urandom;
      b.x_pos = 8'($urandom);
      b.y_pos = 8'($urandom);
    end else begin
      b.height = height_base + 16'($urandom_range(600, 0));
      b.stamp = stamp_now + $urandom_range(50, 0);
      b.x_pos = 8'($urandom_range(3, 0));
      b.y_pos = 8'($urandom_range(3, 0));
    end
    return b;
  endfunction

  // Mostly alerts aimed at a stored reading, with some noise.
  function automatic in_t gen_alert();
    in_t b;
    slot_t s;
    b.command = CMD_QUERY;
    if (ring_fill == 0 || $urandom_range(9, 0) < 2) begin
      b.height = 16'($urandom);
      b.stamp = $urandom;
      b.x_pos = ($urandom_range(1, 0) != 0) ? 8'($urandom) : 8'($urandom_range(3, 0));
      b.y_pos = ($urandom_range(1, 0) != 0) ? 8'($urandom) : 8'($urandom_range(3, 0));
    end else begin
      s = ring[$urandom_range(ring_fill - 1, 0)];
      b.x_pos = s.x_pos;
      b.y_pos = s.y_pos;
      if ($urandom_range(19, 0) == 0) b.x_pos[$urandom_range(7, 0)] ^= 1'b1;
      if ($urandom_range(19, 0) == 0) b.y_pos[$urandom_range(7, 0)] ^= 1'b1;
      b.stamp = s.stamp + near_offset(int'(win_cfg));
      b.height = 16'(s.height + near_offset(int'(tol_cfg)));
    end
    return b;
  endfunction

  // Empty ring, then the window and tolerance edges at their reset values.
  task automatic test_empty_and_defaults();
    send_beat(beat(CMD_QUERY, 16'd0, 32'd0, 8'd0, 8'd0));
    send_beat(beat(CMD_RECORD, 16'd1000, 32'd5000, 8'd10, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd1300, 32'd5100, 8'd10, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd1000, 32'd5101, 8'd10, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd700, 32'd4900, 8'd10, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd1301, 32'd5000, 8'd10, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd1000, 32'd5000, 8'd11, 8'd20));
    send_beat(beat(CMD_QUERY, 16'd1000, 32'd5000, 8'd10, 8'd21));
  endtask

  // Field extremes, zero and full-scale limits, and several matching slots.
  task automatic test_field_extremes();
    set_config(16'd0, 16'd0);
    send_beat(beat(CMD_RECORD, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_beat(beat(CMD_RECORD, 16'd0, 32'd0, 8'hFF, 8'hFF));
    send_beat(beat(CMD_QUERY, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    send_beat(beat(CMD_QUERY, 16'd0, 32'd0, 8'hFF, 8'hFF));
    send_beat(beat(CMD_QUERY, 16'hFFFE, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
    set_config(16'hFFFF, 16'hFFFF);
    // A full-range stamp gap must not wrap into a match.
    send_beat(beat(CMD_QUERY, 16'd0, 32'd0, 8'hFF, 8'hFF));
    send_beat(beat(CMD_QUERY, 16'hFFFF, 32'h0000_FFFF, 8'hFF, 8'hFF));
    send_beat(beat(CMD_RECORD, 16'd7, 32'd10, 8'hFF, 8'hFF));
    // Slots 1 and 2 both qualify for the first query; the lower one must win.
    send_beat(beat(CMD_QUERY, 16'd7, 32'd10, 8'hFF, 8'hFF));
    send_beat(beat(CMD_QUERY, 16'd7, 32'hFFFF_FFF0, 8'hFF, 8'hFF));
  endtask

  // Random records and alerts in bursts, with one full drain halfway.
  task automatic test_random_traffic(input int n, input logic [15:0] window,
                                     input logic [15:0] tol);
    int burst_left;
    burst_left = 0;
    set_config(window, tol);
    stamp_now = ($urandom_range(3, 0) == 0) ? 32'hFFFF_FF80 : $urandom;
    height_base = 16'($urandom);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain_answers();
      stamp_now = stamp_now + $urandom_range(3, 0);
      if ($urandom_range(99, 0) < 55) send_beat(gen_record());
      else send_beat(gen_alert());
      if (burst_left == 0) begin
        burst_left = $urandom_range(30, 1);
        pause_sender(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1));
      end else begin
        burst_left--;
      end
    end
  endtask

  // Receiver holds off for a long stretch while records and alerts keep coming back to back.
  task automatic test_output_hold();
    set_config(16'd200, 16'd500);
    hold_req = 1'b1;
    for (int i = 0; i < 50; i++) begin
      if (i % 5 == 0) send_beat(gen_record());
      else send_beat(gen_alert());
    end
  endtask

  // Receiver stall pattern, changing its density from stretch to stretch.
  initial begin : receiver_pattern
    int seg_left;
    int stall_pct;
    seg_left = 0;
    stall_pct = 0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        seg_left = $urandom_range(200, 20);
        case ($urandom_range(3, 0))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 85;
        endcase
      end
      seg_left--;
      out_stall <= ($urandom_range(99, 0) < stall_pct);
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest waiting answer.
  always @(posedge clk) begin : answer_check
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("result beat with no query waiting: %h", out_data));
      end else begin
        want = pending_answers.pop_front();
        if (out_data.found !== want.found)
          report_mismatch($sformatf("found %b, expected %b", out_data.found, want.found));
        if (out_data.matched_height !== want.matched_height)
          report_mismatch($sformatf("matched_height %0d, expected %0d",
                                    out_data.matched_height, want.matched_height));
        if (out_data.matched_stamp !== want.matched_stamp)
          report_mismatch($sformatf("matched_stamp %0d, expected %0d",
                                    out_data.matched_stamp, want.matched_stamp));
      end
    end
  end

  // Watchdog: too long without any beat moving on either channel.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_and_defaults();
    test_field_extremes();
    test_random_traffic(160, TIME_WINDOW_RST, HEIGHT_TOL_RST);
    test_random_traffic(160, 16'd0, 16'd0);
    test_random_traffic(160, 16'hFFFF, 16'hFFFF);
    test_random_traffic(160, 16'd1, 16'd1);
    test_random_traffic(160, 16'($urandom_range(2000, 0)), 16'($urandom));
    test_output_hold();
    drain_answers();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/rrtm_pkg.sv
hdl/reading_ring_tolerance_match_top.sv
hdl/rrtm_checker.sv
tb/testbench.sv
